### rtl/quad_mesh_node_element_query_macros.svh
// Assertion macros used by the checker in qmneq_checker.sv.
`ifndef QUAD_MESH_NODE_ELEMENT_QUERY_MACROS_SVH
`define QUAD_MESH_NODE_ELEMENT_QUERY_MACROS_SVH

// Same-cycle implication, off during reset.
`define QMNEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qmneq: property failed");

// Next-cycle implication, off during reset.
`define QMNEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qmneq: property failed");

// Next-cycle implication, checked during reset too.
`define QMNEQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("qmneq: property failed");

`endif

### rtl/qmneq_pkg.sv
`default_nettype none
package qmneq_pkg;

    localparam int CW  = 32;
    localparam int DW  = 11;
    localparam int ZW  = 12;
    localparam int NW  = 21;
    localparam int QW  = 32;
    localparam int PW  = QW + DW;
    localparam int LERP_LAT = QW + 3;

    typedef enum logic [1:0] {
        OP_NODE = 2'd0,
        OP_ELEM = 2'd1,
        OP_EDGE = 2'd2,
        OP_BAD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SIDE_BOTTOM = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_TOP    = 2'd2,
        SIDE_LEFT   = 2'd3
    } t_side;

    localparam logic [2:0] CFG_AX = 3'd0;
    localparam logic [2:0] CFG_AY = 3'd1;
    localparam logic [2:0] CFG_BX = 3'd2;
    localparam logic [2:0] CFG_BY = 3'd3;
    localparam logic [2:0] CFG_CX = 3'd4;
    localparam logic [2:0] CFG_CY = 3'd5;
    localparam logic [2:0] CFG_DX = 3'd6;
    localparam logic [2:0] CFG_DY = 3'd7;

    typedef struct packed {
        logic         valid;
        logic         err;
        t_op          op;
        t_side        side;
        logic [ZW-1:0] m1;
        logic [ZW-1:0] w;
        logic [ZW:0]   addend;
        logic          sub;
    } t_dec;

    typedef struct packed {
        logic         valid;
        logic         err;
        t_op          op;
        t_side        side;
        logic [2*ZW-1:0] prod;
        logic [ZW-1:0] w;
        logic [ZW:0]   addend;
        logic          sub;
    } t_mul;

    typedef struct packed {
        logic          valid;
        logic          status;
        logic          node;
        logic [NW-1:0] first;
        logic [NW-1:0] second;
        logic [NW-1:0] third;
        logic [NW-1:0] fourth;
        t_side         side;
    } t_meta;

endpackage
`default_nettype wire

### rtl/qmneq_lerp.sv
`default_nettype none
module qmneq_lerp (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [qmneq_pkg::CW-1:0] i_p,
    input  wire logic signed [qmneq_pkg::CW-1:0] i_q,
    input  wire logic [qmneq_pkg::DW-1:0]      i_k,
    input  wire logic [qmneq_pkg::DW-1:0]      i_n,
    output logic signed [qmneq_pkg::CW-1:0]    o_value
);
    import qmneq_pkg::*;

    logic signed [CW-1:0] r_p1;
    logic signed [CW:0]   r_diff;
    logic [DW-1:0]        r_k1;
    logic [DW-1:0]        r_n1;

    logic [PW-1:0]        r_rem [0:QW];
    logic [QW-1:0]        r_quo [0:QW];
    logic                 r_neg [0:QW];
    logic signed [CW-1:0] r_pp  [0:QW];
    logic [DW-1:0]        r_nn  [0:QW];

    logic [CW:0]          n_mag;
    logic signed [QW+1:0] n_qs;
    logic signed [CW+2:0] n_sum;
    logic signed [CW-1:0] n_out;

    always_comb begin
        n_mag = r_diff[CW] ? -r_diff : r_diff;
        n_qs  = r_neg[QW] ? -$signed({2'b00, r_quo[QW]}) : $signed({2'b00, r_quo[QW]});
        n_sum = (CW+3)'(r_pp[QW]) + (CW+3)'(n_qs);
        if (n_sum > $signed((CW+3)'({1'b0, {(CW-1){1'b1}}}))) begin
            n_out = {1'b0, {(CW-1){1'b1}}};
        end else if (n_sum < -$signed((CW+3)'({1'b1, {(CW-1){1'b0}}}))) begin
            n_out = {1'b1, {(CW-1){1'b0}}};
        end else begin
            n_out = n_sum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= i_p;
            r_diff <= (CW+1)'(i_q) - (CW+1)'(i_p);
            r_k1   <= i_k;
            r_n1   <= i_n;
            r_rem[0] <= PW'(n_mag[QW-1:0]) * PW'(r_k1);
            r_quo[0] <= '0;
            r_neg[0] <= r_diff[CW];
            r_pp[0]  <= r_p1;
            r_nn[0]  <= r_n1;
            o_value  <= n_out;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        logic [PW:0] n_sh;
        logic        n_ge;
        always_comb begin
            n_sh = (PW+1)'(r_nn[j-1]) << (QW - j);
            n_ge = {1'b0, r_rem[j-1]} >= n_sh;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_ge ? PW'({1'b0, r_rem[j-1]} - n_sh) : r_rem[j-1];
                r_quo[j] <= r_quo[j-1] | (n_ge ? (QW'(1) << (QW - j)) : '0);
                r_neg[j] <= r_neg[j-1];
                r_pp[j]  <= r_pp[j-1];
                r_nn[j]  <= r_nn[j-1];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/quad_mesh_node_element_query.sv
// Structured quad mesh query engine.
// Input channel: i_valid / o_stall with opcode, cells_across, cells_up, row,
// column and edge_index. A transaction is taken when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall with one result per
// query (status, point, four node numbers, boundary side).
// Config channel: i_cfg_valid / o_cfg_ready, index 0..7 selects corner
// A..D x/y (Q16.16). Write only while no query is in flight.
// Throughput: one query per cycle while the output is not stalled; set by
// the two chained bit-per-stage divider pipelines (row interpolation, then
// column interpolation).
// Reset clears all valid bits and the corners to zero.
// When the output is stalled, the whole pipeline holds and o_stall rises;
// no transaction is lost or repeated.
`default_nettype none
module quad_mesh_node_element_query #(
    parameter int MAX_CELLS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [qmneq_pkg::DW-1:0]      i_cells_across,
    input  wire logic [qmneq_pkg::DW-1:0]      i_cells_up,
    input  wire logic [qmneq_pkg::DW-1:0]      i_row,
    input  wire logic [qmneq_pkg::DW-1:0]      i_column,
    input  wire logic [qmneq_pkg::ZW-1:0]      i_edge_index,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [qmneq_pkg::CW-1:0]      i_cfg_data,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_status,
    output logic signed [qmneq_pkg::CW-1:0]    o_point_x,
    output logic signed [qmneq_pkg::CW-1:0]    o_point_y,
    output logic [qmneq_pkg::NW-1:0]           o_node_first,
    output logic [qmneq_pkg::NW-1:0]           o_node_second,
    output logic [qmneq_pkg::NW-1:0]           o_node_third,
    output logic [qmneq_pkg::NW-1:0]           o_node_fourth,
    output logic [1:0]                         o_boundary_side
);
    import qmneq_pkg::*;

    localparam int DLY = 2 * LERP_LAT - 3;

    logic en;

    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_dx, r_dy;

    logic          r_s0_valid;
    t_op           r_s0_op;
    logic [DW-1:0] r_s0_nx, r_s0_ny, r_s0_row, r_s0_col;
    logic [ZW-1:0] r_s0_z;

    t_dec  r_s1, n_s1;
    t_mul  r_s2;
    t_meta r_s3, n_s3;
    t_meta r_dly [0:DLY-1];

    logic [DW-1:0] r_cd_col [0:LERP_LAT-1];
    logic [DW-1:0] r_cd_nx  [0:LERP_LAT-1];

    logic signed [CW-1:0] lx, ly, rx, ry, px, py;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_bx <= '0; r_by <= '0;
            r_cx <= '0; r_cy <= '0; r_dx <= '0; r_dy <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_AX: r_ax <= i_cfg_data;
                CFG_AY: r_ay <= i_cfg_data;
                CFG_BX: r_bx <= i_cfg_data;
                CFG_BY: r_by <= i_cfg_data;
                CFG_CX: r_cx <= i_cfg_data;
                CFG_CY: r_cy <= i_cfg_data;
                CFG_DX: r_dx <= i_cfg_data;
                CFG_DY: r_dy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_op  <= t_op'(i_opcode);
            r_s0_nx  <= i_cells_across;
            r_s0_ny  <= i_cells_up;
            r_s0_row <= i_row;
            r_s0_col <= i_column;
            r_s0_z   <= i_edge_index;
        end
    end

    qmneq_lerp u_lx (.i_clk, .i_en(en), .i_p(r_ax), .i_q(r_dx), .i_k(r_s0_row),
                     .i_n(r_s0_ny), .o_value(lx));
    qmneq_lerp u_ly (.i_clk, .i_en(en), .i_p(r_ay), .i_q(r_dy), .i_k(r_s0_row),
                     .i_n(r_s0_ny), .o_value(ly));
    qmneq_lerp u_rx (.i_clk, .i_en(en), .i_p(r_bx), .i_q(r_cx), .i_k(r_s0_row),
                     .i_n(r_s0_ny), .o_value(rx));
    qmneq_lerp u_ry (.i_clk, .i_en(en), .i_p(r_by), .i_q(r_cy), .i_k(r_s0_row),
                     .i_n(r_s0_ny), .o_value(ry));
    qmneq_lerp u_px (.i_clk, .i_en(en), .i_p(lx), .i_q(rx),
                     .i_k(r_cd_col[LERP_LAT-1]), .i_n(r_cd_nx[LERP_LAT-1]), .o_value(px));
    qmneq_lerp u_py (.i_clk, .i_en(en), .i_p(ly), .i_q(ry),
                     .i_k(r_cd_col[LERP_LAT-1]), .i_n(r_cd_nx[LERP_LAT-1]), .o_value(py));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd_col[0] <= r_s0_col;
            r_cd_nx[0]  <= r_s0_nx;
            for (int i = 1; i < LERP_LAT; i++) begin
                r_cd_col[i] <= r_cd_col[i-1];
                r_cd_nx[i]  <= r_cd_nx[i-1];
            end
        end
    end

    always_comb begin
        logic [ZW:0] nx, ny, z, r, c, perim;
        logic        bad;
        nx    = (ZW+1)'(r_s0_nx);
        ny    = (ZW+1)'(r_s0_ny);
        z     = (ZW+1)'(r_s0_z);
        r     = (ZW+1)'(r_s0_row);
        c     = (ZW+1)'(r_s0_col);
        perim = (nx + ny) << 1;
        bad   = (nx == '0) || (ny == '0) || (32'(r_s0_nx) > 32'(MAX_CELLS))
                || (32'(r_s0_ny) > 32'(MAX_CELLS)) || (r_s0_op == OP_BAD);
        n_s1.valid  = r_s0_valid;
        n_s1.op     = r_s0_op;
        n_s1.w      = ZW'(nx + 1'b1);
        n_s1.side   = SIDE_BOTTOM;
        n_s1.m1     = '0;
        n_s1.addend = '0;
        n_s1.sub    = 1'b0;
        n_s1.err    = bad;
        unique case (r_s0_op)
            OP_NODE: n_s1.err = bad || (r > ny) || (c > nx);
            OP_ELEM: begin
                n_s1.err    = bad || (r >= ny) || (c >= nx);
                n_s1.m1     = ZW'(r);
                n_s1.addend = c + 1'b1;
            end
            OP_EDGE: begin
                n_s1.err = bad || (z >= perim);
                priority if (z < nx) begin
                    n_s1.addend = z + 1'b1;
                end else if (z < nx + ny) begin
                    n_s1.side = SIDE_RIGHT;
                    n_s1.m1   = ZW'(z - nx + 1'b1);
                end else if (z < (nx << 1) + ny) begin
                    n_s1.side   = SIDE_TOP;
                    n_s1.m1     = ZW'(ny + 1'b1);
                    n_s1.addend = z - nx - ny;
                    n_s1.sub    = 1'b1;
                end else begin
                    n_s1.side   = SIDE_LEFT;
                    n_s1.m1     = ZW'(perim - z);
                    n_s1.addend = (ZW+1)'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        logic [NW-1:0] a, w;
        w = NW'(r_s2.w);
        a = r_s2.sub ? NW'(r_s2.prod) - NW'(r_s2.addend)
                     : NW'(r_s2.prod) + NW'(r_s2.addend);
        n_s3.valid  = r_s2.valid;
        n_s3.status = r_s2.err;
        n_s3.node   = (r_s2.op == OP_NODE) && !r_s2.err;
        n_s3.first  = '0;
        n_s3.second = '0;
        n_s3.third  = '0;
        n_s3.fourth = '0;
        n_s3.side   = SIDE_BOTTOM;
        if (!r_s2.err && r_s2.op == OP_ELEM) begin
            n_s3.first  = a;
            n_s3.second = a + 1'b1;
            n_s3.third  = a + w + 1'b1;
            n_s3.fourth = a + w;
        end else if (!r_s2.err && r_s2.op == OP_EDGE) begin
            n_s3.first = a;
            n_s3.side  = r_s2.side;
            unique case (r_s2.side)
                SIDE_BOTTOM: n_s3.second = a + 1'b1;
                SIDE_RIGHT:  n_s3.second = a + w;
                SIDE_TOP:    n_s3.second = a - 1'b1;
                SIDE_LEFT:   n_s3.second = a - w;
                default:     n_s3.second = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            for (int i = 0; i < DLY; i++) begin
                r_dly[i].valid <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
            r_s1       <= n_s1;
            r_s2.valid  <= r_s1.valid;
            r_s2.err    <= r_s1.err;
            r_s2.op     <= r_s1.op;
            r_s2.side   <= r_s1.side;
            r_s2.prod   <= (2*ZW)'(r_s1.m1) * (2*ZW)'(r_s1.w);
            r_s2.w      <= r_s1.w;
            r_s2.addend <= r_s1.addend;
            r_s2.sub    <= r_s1.sub;
            r_s3       <= n_s3;
            r_dly[0]   <= r_s3;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
            o_valid <= r_dly[DLY-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_status        <= r_dly[DLY-1].status;
            o_point_x       <= r_dly[DLY-1].node ? px : '0;
            o_point_y       <= r_dly[DLY-1].node ? py : '0;
            o_node_first    <= r_dly[DLY-1].first;
            o_node_second   <= r_dly[DLY-1].second;
            o_node_third    <= r_dly[DLY-1].third;
            o_node_fourth   <= r_dly[DLY-1].fourth;
            o_boundary_side <= r_dly[DLY-1].side;
        end
    end

endmodule
`default_nettype wire

### rtl/qmneq_checker.sv
`default_nettype none
`include "quad_mesh_node_element_query_macros.svh"
module qmneq_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic                       o_status,
    input wire logic [qmneq_pkg::CW-1:0]   o_point_x,
    input wire logic [qmneq_pkg::NW-1:0]   o_node_first,
    input wire logic [qmneq_pkg::NW-1:0]   o_node_third,
    input wire logic [1:0]                 o_boundary_side
);
    import qmneq_pkg::*;

    `QMNEQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `QMNEQ_ASSERT_NEXT_ALWAYS(a_reset, i_clk, !i_rst_n, !o_valid)
    `QMNEQ_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_status,
        o_point_x == '0 && o_node_first == '0 && o_boundary_side == SIDE_BOTTOM)
    `QMNEQ_ASSERT_IMP(a_edge_only, i_clk, i_rst_n, o_valid && o_boundary_side != SIDE_BOTTOM,
        o_node_third == '0 && o_point_x == '0 && o_node_first != '0)

endmodule

bind quad_mesh_node_element_query qmneq_checker u_qmneq_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_status, .o_point_x,
    .o_node_first, .o_node_third, .o_boundary_side
);
`default_nettype wire

### test/mesh_query_checker.sv
`timescale 1ns / 1ps
module mesh_query_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [10:0] i_cells_across,
    input  logic [10:0] i_cells_up,
    input  logic [10:0] i_row,
    input  logic [10:0] i_column,
    input  logic [11:0] i_edge_index,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_status,
    input  logic [31:0] o_point_x,
    input  logic [31:0] o_point_y,
    input  logic [20:0] o_node_first,
    input  logic [20:0] o_node_second,
    input  logic [20:0] o_node_third,
    input  logic [20:0] o_node_fourth,
    input  logic [1:0]  o_boundary_side,
    output int          fail_count,
    output int          pending
);
    import qmneq_pkg::*;

    localparam int MAX_CELLS = 1024;

    typedef struct packed {
        logic        status;
        logic [31:0] px;
        logic [31:0] py;
        logic [20:0] n1;
        logic [20:0] n2;
        logic [20:0] n3;
        logic [20:0] n4;
        logic [1:0]  side;
    } t_answer;

    logic signed [31:0] corner [8];
    t_answer answers [$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint blend(longint p, longint q, longint k, longint n);
        longint prod;
        prod = (q - p) * k;
        return clamp32(p + prod / n);
    endfunction

    function automatic t_answer answer_query(logic [1:0] op, longint nx, longint ny,
                                             longint r, longint c, longint z);
        t_answer a;
        longint lx, ly, rx, ry, w, base, s, e, k;
        a = '0;
        if (nx == 0 || ny == 0 || nx > MAX_CELLS || ny > MAX_CELLS || op == OP_BAD) begin
            a.status = 1'b1;
            return a;
        end
        w = nx + 1;
        if (op == OP_NODE) begin
            if (r > ny || c > nx) begin
                a.status = 1'b1;
                return a;
            end
            lx = blend(corner[CFG_AX], corner[CFG_DX], r, ny);
            ly = blend(corner[CFG_AY], corner[CFG_DY], r, ny);
            rx = blend(corner[CFG_BX], corner[CFG_CX], r, ny);
            ry = blend(corner[CFG_BY], corner[CFG_CY], r, ny);
            a.px = 32'(blend(lx, rx, c, nx));
            a.py = 32'(blend(ly, ry, c, nx));
        end else if (op == OP_ELEM) begin
            if (r >= ny || c >= nx) begin
                a.status = 1'b1;
                return a;
            end
            base = r * w + c + 1;
            a.n1 = 21'(base);
            a.n2 = 21'(base + 1);
            a.n3 = 21'(base + w + 1);
            a.n4 = 21'(base + w);
        end else begin
            if (z >= 2 * nx + 2 * ny) begin
                a.status = 1'b1;
                return a;
            end
            if (z < nx) begin
                s = z + 1; e = z + 2; a.side = SIDE_BOTTOM;
            end else if (z < nx + ny) begin
                k = z - nx; s = k * w + w; e = s + w; a.side = SIDE_RIGHT;
            end else if (z < 2 * nx + ny) begin
                k = z - nx - ny; s = w * (ny + 1) - k; e = s - 1; a.side = SIDE_TOP;
            end else begin
                k = z - 2 * nx - ny; s = (ny - k) * w + 1; e = s - w; a.side = SIDE_LEFT;
            end
            a.n1 = 21'(s);
            a.n2 = 21'(e);
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) corner[i] <= '0;
            fail_count <= 0;
            answers.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) corner[i_cfg_index] <= i_cfg_data;
            if (i_valid && !o_stall)
                answers.push_back(answer_query(i_opcode, i_cells_across, i_cells_up,
                                               i_row, i_column, i_edge_index));
            if (o_valid && !i_stall) begin
                if (answers.size() == 0) begin
                    $error("unexpected result");
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers.pop_front();
                    if (want != {o_status, o_point_x, o_point_y, o_node_first,
                                 o_node_second, o_node_third, o_node_fourth,
                                 o_boundary_side}) begin
                        fail_count <= fail_count + 1;
                        if (want.status != o_status)
                            $error("status exp %0d got %0d", want.status, o_status);
                        if (want.px != o_point_x)
                            $error("point_x exp %h got %h", want.px, o_point_x);
                        if (want.py != o_point_y)
                            $error("point_y exp %h got %h", want.py, o_point_y);
                        if (want.n1 != o_node_first)
                            $error("node_first exp %0d got %0d", want.n1, o_node_first);
                        if (want.n2 != o_node_second)
                            $error("node_second exp %0d got %0d", want.n2, o_node_second);
                        if (want.n3 != o_node_third)
                            $error("node_third exp %0d got %0d", want.n3, o_node_third);
                        if (want.n4 != o_node_fourth)
                            $error("node_fourth exp %0d got %0d", want.n4, o_node_fourth);
                        if (want.side != o_boundary_side)
                            $error("boundary_side exp %0d got %0d", want.side,
                                   o_boundary_side);
                    end
                end
            end
        end
    end

    assign pending = answers.size();
endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
    import qmneq_pkg::*;

    localparam int LIMIT = 5000;
    localparam int DRAIN = 100;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [1:0]  i_opcode;
    logic [10:0] i_cells_across, i_cells_up, i_row, i_column;
    logic [11:0] i_edge_index;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid, i_stall, o_status;
    logic [31:0] o_point_x, o_point_y;
    logic [20:0] o_node_first, o_node_second, o_node_third, o_node_fourth;
    logic [1:0]  o_boundary_side;
    int          fail_count, pending, idle_cycles, stall_mode;

    quad_mesh_node_element_query uut (.*);
    mesh_query_checker checker_0 (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_corner(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send(logic [1:0] op, int nx, int ny, int r, int c, int z);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_cells_across <= 11'(nx);
        i_cells_up <= 11'(ny);
        i_row <= 11'(r);
        i_column <= 11'(c);
        i_edge_index <= 12'(z);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic random_query();
        int nx, ny, pick;
        pick = $urandom_range(0, 19);
        nx = (pick < 14) ? $urandom_range(1, 16) : (pick < 18) ? $urandom_range(1, 1024)
             : $urandom_range(0, 2047);
        ny = (pick < 14) ? $urandom_range(1, 16) : (pick < 18) ? $urandom_range(1, 1024)
             : $urandom_range(0, 2047);
        if ($urandom_range(0, 15) == 0)
            send(2'($urandom_range(0, 3)), nx, ny, $urandom_range(0, 2047),
                 $urandom_range(0, 2047), $urandom_range(0, 4095));
        else
            send(2'($urandom_range(0, 2)), nx, ny, $urandom_range(0, ny + 1),
                 $urandom_range(0, nx + 1), $urandom_range(0, 2 * nx + 2 * ny + 1));
    endtask

    task automatic load_corners(int mode);
        for (int i = 0; i < 8; i++) begin
            case (mode)
                0: write_corner(i[2:0], (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
                1: write_corner(i[2:0], $urandom_range(0, 8) << 16);
                2: write_corner(i[2:0], (i % 3) ? 32'h7FFF_FFFF : 32'h8000_0000);
                default: write_corner(i[2:0], $urandom());
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = '0;
        i_cells_across = '0;
        i_cells_up = '0;
        i_row = '0;
        i_column = '0;
        i_edge_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_stall = 1'b0;
        stall_mode = 0;
        idle_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_corners(1);
        send(OP_NODE, 1, 1, 0, 0, 0);
        send(OP_NODE, 4, 3, 3, 4, 0);
        send(OP_NODE, 1024, 1024, 1024, 1024, 0);
        send(OP_NODE, 5, 5, 6, 0, 0);
        send(OP_NODE, 5, 5, 0, 6, 0);
        send(OP_ELEM, 3, 2, 1, 2, 0);
        send(OP_ELEM, 1024, 1024, 1023, 1023, 0);
        send(OP_ELEM, 3, 2, 2, 0, 0);
        send(OP_ELEM, 3, 2, 0, 3, 0);
        for (int z = 0; z <= 10; z++) send(OP_EDGE, 3, 2, 0, 0, z);
        send(OP_EDGE, 1024, 1024, 0, 0, 4095);
        send(OP_BAD, 3, 3, 0, 0, 0);
        send(OP_NODE, 0, 3, 0, 0, 0);
        send(OP_NODE, 3, 1025, 0, 0, 0);
        send(OP_ELEM, 2047, 2047, 2047, 2047, 4095);
        i_valid <= 1'b0;
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            stall_mode = phase;
            load_corners(phase == 1 ? 3 : phase == 3 ? 2 : phase);
            for (int n = 0; n < 250; ) begin
                int burst;
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 250; b++, n++) random_query();
                if ($urandom_range(0, 2) != 0) pause();
                if (n == 120) begin
                    i_valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
            i_valid <= 1'b0;
            stall_mode = 0;
            settle();
        end

        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
